### rtl/core/sorv_pkg.sv
// Shared constants, widths and the CORDIC angle table for the revolution vertex block.
`timescale 1ns / 1ps
package sorv_pkg;

  // Field widths
  localparam int IDX_W = 12;
  localparam int POS_W = 24;
  localparam int NRM_W = 18;
  localparam int CFG_W = 13;
  localparam int TRIG_W = 18;
  localparam int Q_FRAC = 16;

  // Step count defaults
  localparam int DEF_MAX_STEPS = 4096;
  localparam int RESET_STEPS = 16;

  // Pipeline shape: quotient/root/rotation digits resolved per stage
  localparam int DIG_PER_STAGE = 4;
  localparam int PHASE_W = 32;

  // CORDIC
  localparam int CORDIC_ITERS = 28;
  localparam int CORDIC_W = 32;
  localparam int CORDIC_RND_SH = 14;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032875;
  localparam int TRIG_ONE = 65536;

  // Quadrant codes (phase bits 31..30)
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Normal length: floor(sqrt((nx^2+ny^2) << 16))
  localparam int SQ_SHIFT = 16;
  localparam int SQV_W = 2 * NRM_W + SQ_SHIFT;
  localparam int LEN_W = SQV_W / 2;

  // Normal divide: quotient bits and dividend width
  localparam int NQ_W = NRM_W;
  localparam int NUM_W = LEN_W + NQ_W;

  // Arctangent table in units of 2^30 per quarter turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
    logic signed [CORDIC_W-1:0] a;
    case (i)
      0: a = 32'sd536870912;
      1: a = 32'sd316933406;
      2: a = 32'sd167458907;
      3: a = 32'sd85004756;
      4: a = 32'sd42667331;
      5: a = 32'sd21354465;
      6: a = 32'sd10679838;
      7: a = 32'sd5340245;
      8: a = 32'sd2670163;
      9: a = 32'sd1335087;
      10: a = 32'sd667544;
      11: a = 32'sd333772;
      12: a = 32'sd166886;
      13: a = 32'sd83443;
      14: a = 32'sd41722;
      15: a = 32'sd20861;
      16: a = 32'sd10430;
      17: a = 32'sd5215;
      18: a = 32'sd2608;
      19: a = 32'sd1304;
      20: a = 32'sd652;
      21: a = 32'sd326;
      22: a = 32'sd163;
      23: a = 32'sd81;
      24: a = 32'sd41;
      25: a = 32'sd20;
      26: a = 32'sd10;
      27: a = 32'sd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/sorv_delay.sv
// Enabled shift-register delay line that keeps side data aligned with the datapath.
`timescale 1ns / 1ps
module sorv_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] dly_r [0:N-1];

  // Shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= d;
      for (int k = 1; k < N; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign q = dly_r[N-1];

endmodule

### rtl/core/sorv_div.sv
// Pipelined restoring divider: BPS quotient bits per stage; caller keeps starting remainder below divisor (unchecked).
`timescale 1ns / 1ps
module sorv_div #(
  parameter int DW  = 13,
  parameter int QW  = 32,
  parameter int BPS = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] dvs_in,
  output logic [QW-1:0] quo_out
);

  localparam int NST = (QW + BPS - 1) / BPS;

  logic [DW-1:0] rem_p [0:NST];
  logic [QW-1:0] low_p [0:NST];
  logic [QW-1:0] quo_p [0:NST];
  logic [DW-1:0] dvs_p [0:NST];

  assign rem_p[0] = rem_in;
  assign low_p[0] = low_in;
  assign quo_p[0] = '0;
  assign dvs_p[0] = dvs_in;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [DW-1:0] rem_c, rem_r, dvs_r;
    logic [QW-1:0] low_c, quo_c, low_r, quo_r;
    logic [DW:0]   trial;

    // Shift-compare-subtract, one quotient bit per step
    always_comb begin
      rem_c = rem_p[k];
      low_c = low_p[k];
      quo_c = quo_p[k];
      trial = '0;
      for (int j = 0; j < BPS; j++) begin
        if (k * BPS + j < QW) begin
          trial = {rem_c, low_c[QW-1]};
          low_c = {low_c[QW-2:0], 1'b0};
          if (trial >= {1'b0, dvs_p[k]}) begin
            rem_c = DW'(trial - {1'b0, dvs_p[k]});
            quo_c = {quo_c[QW-2:0], 1'b1};
          end else begin
            rem_c = trial[DW-1:0];
            quo_c = {quo_c[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_c;
        low_r <= low_c;
        quo_r <= quo_c;
        dvs_r <= dvs_p[k];
      end
    end

    assign rem_p[k+1] = rem_r;
    assign low_p[k+1] = low_r;
    assign quo_p[k+1] = quo_r;
    assign dvs_p[k+1] = dvs_r;
  end

  assign quo_out = quo_p[NST];

endmodule

### rtl/core/sorv_isqrt.sv
// Pipelined integer square root of the scaled squared normal length.
`timescale 1ns / 1ps
module sorv_isqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [sorv_pkg::NRM_W-1:0] nx,
  input  logic signed [sorv_pkg::NRM_W-1:0] ny,
  output logic [sorv_pkg::LEN_W-1:0]        len
);
  import sorv_pkg::*;

  localparam int NST = (LEN_W + DIG_PER_STAGE - 1) / DIG_PER_STAGE;
  localparam int REM_W = LEN_W + 3;
  localparam int SQ_W = 2 * NRM_W;

  logic signed [SQ_W:0] sq_nxt;
  logic [SQ_W-1:0]      sq_r;

  logic [REM_W-1:0] rem_p  [0:NST];
  logic [LEN_W-1:0] root_p [0:NST];
  logic [SQV_W-1:0] val_p  [0:NST];

  // Squared length
  assign sq_nxt = nx * nx + ny * ny;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt[SQ_W-1:0];
    end
  end

  assign rem_p[0]  = '0;
  assign root_p[0] = '0;
  assign val_p[0]  = {sq_r, {SQ_SHIFT{1'b0}}};

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [REM_W-1:0] rem_c, rem_r, t;
    logic [LEN_W-1:0] root_c, root_r;
    logic [SQV_W-1:0] val_c, val_r;
    logic [REM_W-1:0] trial;

    // Digit-by-digit root: bring down two bits, try (root << 2) | 1
    always_comb begin
      rem_c  = rem_p[k];
      root_c = root_p[k];
      val_c  = val_p[k];
      t      = '0;
      trial  = '0;
      for (int j = 0; j < DIG_PER_STAGE; j++) begin
        if (k * DIG_PER_STAGE + j < LEN_W) begin
          t     = {rem_c[REM_W-3:0], val_c[SQV_W-1 -: 2]};
          val_c = {val_c[SQV_W-3:0], 2'b00};
          trial = REM_W'({root_c, 2'b01});
          if (t >= trial) begin
            rem_c  = t - trial;
            root_c = {root_c[LEN_W-2:0], 1'b1};
          end else begin
            rem_c  = t;
            root_c = {root_c[LEN_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_c;
        root_r <= root_c;
        val_r  <= val_c;
      end
    end

    assign rem_p[k+1]  = rem_r;
    assign root_p[k+1] = root_r;
    assign val_p[k+1]  = val_r;
  end

  assign len = root_p[NST];

endmodule

### rtl/core/sorv_cordic.sv
// Pipelined CORDIC: phase to cosine and sine in Q1.16 with quadrant folding.
`timescale 1ns / 1ps
module sorv_cordic (
  input  logic                               clk,
  input  logic                               en,
  input  logic [sorv_pkg::PHASE_W-1:0]       phase,
  output logic signed [sorv_pkg::TRIG_W-1:0] cos_q,
  output logic signed [sorv_pkg::TRIG_W-1:0] sin_q
);
  import sorv_pkg::*;

  localparam int NST = (CORDIC_ITERS + DIG_PER_STAGE - 1) / DIG_PER_STAGE;

  logic signed [CORDIC_W-1:0] x_p [0:NST];
  logic signed [CORDIC_W-1:0] y_p [0:NST];
  logic signed [CORDIC_W-1:0] z_p [0:NST];
  logic [1:0]                 quad_p [0:NST];

  assign x_p[0]    = CORDIC_X0;
  assign y_p[0]    = '0;
  assign z_p[0]    = {2'b00, phase[PHASE_W-3:0]};
  assign quad_p[0] = phase[PHASE_W-1 -: 2];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic signed [CORDIC_W-1:0] x_c, y_c, z_c, dx, dy;
    logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
    logic [1:0]                 quad_r;

    // Rotation micro-steps
    always_comb begin
      x_c = x_p[k];
      y_c = y_p[k];
      z_c = z_p[k];
      dx  = '0;
      dy  = '0;
      for (int j = 0; j < DIG_PER_STAGE; j++) begin
        if (k * DIG_PER_STAGE + j < CORDIC_ITERS) begin
          dx = y_c >>> (k * DIG_PER_STAGE + j);
          dy = x_c >>> (k * DIG_PER_STAGE + j);
          if (!z_c[CORDIC_W-1]) begin
            x_c = x_c - dx;
            y_c = y_c + dy;
            z_c = z_c - atan_turn(k * DIG_PER_STAGE + j);
          end else begin
            x_c = x_c + dx;
            y_c = y_c - dy;
            z_c = z_c + atan_turn(k * DIG_PER_STAGE + j);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r    <= x_c;
        y_r    <= y_c;
        z_r    <= z_c;
        quad_r <= quad_p[k];
      end
    end

    assign x_p[k+1]    = x_r;
    assign y_p[k+1]    = y_r;
    assign z_p[k+1]    = z_r;
    assign quad_p[k+1] = quad_r;
  end

  // Round to Q1.16, clamp to +-1.0
  function automatic logic signed [TRIG_W-1:0] rnd_trig(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    logic signed [TRIG_W-1:0]   o;
    r = (v + CORDIC_W'(1 << (CORDIC_RND_SH - 1))) >>> CORDIC_RND_SH;
    if (r > CORDIC_W'(TRIG_ONE)) begin
      o = TRIG_W'(TRIG_ONE);
    end else if (r < -CORDIC_W'(TRIG_ONE)) begin
      o = -TRIG_W'(TRIG_ONE);
    end else begin
      o = r[TRIG_W-1:0];
    end
    return o;
  endfunction

  logic signed [TRIG_W-1:0] cc, ss, cos_nxt, sin_nxt, cos_r, sin_r;

  assign cc = rnd_trig(x_p[NST]);
  assign ss = rnd_trig(y_p[NST]);

  // Fold back to the full circle
  always_comb begin
    unique case (quad_p[NST])
      QUAD_0: begin
        cos_nxt = cc;
        sin_nxt = ss;
      end
      QUAD_1: begin
        cos_nxt = -ss;
        sin_nxt = cc;
      end
      QUAD_2: begin
        cos_nxt = -cc;
        sin_nxt = -ss;
      end
      QUAD_3: begin
        cos_nxt = ss;
        sin_nxt = -cc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

### rtl/core/surface_of_revolution_vertex.sv
// Top level: one profile vertex rotated about the y axis, with its unit normal.
`timescale 1ns / 1ps
// Usage
//   Configuration: cfg_we writes cfg_wdata into the step count (values above
//   MAX_STEPS are stored as MAX_STEPS). Write only while no transfer is in flight.
//   Input channel: in_valid / in_stall, one vertex (step index, Q8.16 position,
//   Q1.16 profile normal) per transfer.
//   Output channel: out_valid / out_stall, one result per input transfer, in
//   order: rotated position, unit normal, zero_normal and index_error flags.
//   Depth: 24 register stages, set by the 32-bit phase divider (8 stages), the
//   CORDIC (7 stages plus rounding), product and rounding stages, the 18-bit
//   normal dividers (5 stages) and the output register.
//   Throughput: one vertex per cycle while the output is not stalled.
//   Stall: when the output register holds a result and out_stall is high, the
//   whole pipeline freezes and in_stall goes high; nothing is lost or repeated.
//   Reset: synchronous, active-low; drops all items in flight and sets the
//   step count to 16.
module surface_of_revolution_vertex #(
  parameter int MAX_STEPS = sorv_pkg::DEF_MAX_STEPS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sorv_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sorv_pkg::IDX_W-1:0]        in_step_index,
  input  logic signed [sorv_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [sorv_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [sorv_pkg::NRM_W-1:0] in_nrm_in_x,
  input  logic signed [sorv_pkg::NRM_W-1:0] in_nrm_in_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sorv_pkg::POS_W-1:0] out_x,
  output logic signed [sorv_pkg::POS_W-1:0] out_y,
  output logic signed [sorv_pkg::POS_W-1:0] out_z,
  output logic signed [sorv_pkg::NRM_W-1:0] out_nrm_out_x,
  output logic signed [sorv_pkg::NRM_W-1:0] out_nrm_out_y,
  output logic signed [sorv_pkg::NRM_W-1:0] out_nrm_out_z,
  output logic                              out_zero_normal,
  output logic                              out_index_error
);
  import sorv_pkg::*;

  localparam int CNT_CAP  = (MAX_STEPS > RESET_STEPS) ? MAX_STEPS : RESET_STEPS;
  localparam int CNT_W    = $clog2(CNT_CAP + 1);
  localparam int DIV_LAT  = (PHASE_W + DIG_PER_STAGE - 1) / DIG_PER_STAGE;
  localparam int COR_LAT  = (CORDIC_ITERS + DIG_PER_STAGE - 1) / DIG_PER_STAGE + 1;
  localparam int TRIG_LAT = DIV_LAT + COR_LAT;
  localparam int SQ_LAT   = 1 + (LEN_W + DIG_PER_STAGE - 1) / DIG_PER_STAGE;
  localparam int NDIV_LAT = (NQ_W + DIG_PER_STAGE - 1) / DIG_PER_STAGE;
  localparam int LAT      = TRIG_LAT + 2 + NDIV_LAT + 1;
  localparam int PROD_W   = POS_W + TRIG_W;
  localparam int NPROD_W  = NRM_W + TRIG_W;
  localparam int NRM_MAX  = (1 << (NRM_W - 1)) - 1;
  localparam int NRM_MIN_MAG = 1 << (NRM_W - 1);

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic                    err;
    logic                    zn;
  } side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ox;
    logic signed [POS_W-1:0] oy;
    logic signed [POS_W-1:0] oz;
    logic [2:0]              ovf;
    logic [2:0]              neg;
    logic                    err;
    logic                    zn;
  } post_t;

  // Step count register
  logic [CNT_W-1:0] step_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= CNT_W'(RESET_STEPS);
    end else if (cfg_we) begin
      if (32'(cfg_wdata) > MAX_STEPS) begin
        step_count_r <= CNT_W'(MAX_STEPS);
      end else begin
        step_count_r <= CNT_W'(cfg_wdata);
      end
    end
  end

  // Pipeline advance and valid bits
  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv      = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Input classification
  logic  in_err, in_zn;
  side_t side_in, side_t1;

  assign in_err = 32'(in_step_index) >= 32'(step_count_r);
  assign in_zn  = (in_nrm_in_x == '0) && (in_nrm_in_y == '0);

  assign side_in = '{px: in_pos_x, py: in_pos_y, nx: in_nrm_in_x, ny: in_nrm_in_y,
                     err: in_err, zn: in_zn};

  // Phase = floor(index * 2^32 / count)
  logic [PHASE_W-1:0] phase;

  sorv_div #(.DW(CNT_W), .QW(PHASE_W), .BPS(DIG_PER_STAGE)) u_phase_div (
    .clk     (clk),
    .en      (adv),
    .rem_in  (in_err ? '0 : CNT_W'(in_step_index)),
    .low_in  ('0),
    .dvs_in  (step_count_r),
    .quo_out (phase)
  );

  logic signed [TRIG_W-1:0] cos_q, sin_q;

  sorv_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .phase (phase),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  sorv_delay #(.W($bits(side_t)), .N(TRIG_LAT)) u_side_dly (
    .clk (clk),
    .en  (adv),
    .d   (side_in),
    .q   (side_t1)
  );

  // Normal length runs alongside the angle path
  logic [LEN_W-1:0] len_sq, len_t1;

  sorv_isqrt u_isqrt (
    .clk (clk),
    .en  (adv),
    .nx  (in_nrm_in_x),
    .ny  (in_nrm_in_y),
    .len (len_sq)
  );

  sorv_delay #(.W(LEN_W), .N(TRIG_LAT - SQ_LAT)) u_len_dly (
    .clk (clk),
    .en  (adv),
    .d   (len_sq),
    .q   (len_t1)
  );

  // Product stage
  logic signed [PROD_W-1:0]  m_px_c_r, m_px_s_r;
  logic signed [NPROD_W-1:0] m_nx_c_r, m_nx_s_r;
  logic signed [POS_W-1:0]   px_t1;
  logic signed [NRM_W-1:0]   nx_t1;
  side_t                     side_m_r;
  logic [LEN_W-1:0]          len_m_r;

  assign px_t1 = side_t1.px;
  assign nx_t1 = side_t1.nx;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_px_c_r <= px_t1 * cos_q;
      m_px_s_r <= px_t1 * sin_q;
      m_nx_c_r <= nx_t1 * cos_q;
      m_nx_s_r <= nx_t1 * sin_q;
      side_m_r <= side_t1;
      len_m_r  <= len_t1;
    end
  end

  // Position rounding and saturation
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] r;
    logic signed [POS_W-1:0] o;
    r = (v + (PROD_W+1)'(1 << (Q_FRAC - 1))) >>> Q_FRAC;
    if (r > (PROD_W+1)'((1 << (POS_W - 1)) - 1)) begin
      o = {1'b0, {(POS_W-1){1'b1}}};
    end else if (r < -(PROD_W+1)'(1 << (POS_W - 1))) begin
      o = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      o = r[POS_W-1:0];
    end
    return o;
  endfunction

  logic signed [POS_W-1:0]   ox_nxt, oz_nxt, py_m;
  logic signed [NPROD_W-1:0] abs_x, abs_z;
  logic signed [NRM_W:0]     abs_y;
  logic signed [NRM_W-1:0]   ny_m;
  logic [NUM_W-1:0]          dvd [0:2];
  logic [LEN_W-1:0]          half_len;
  logic [2:0]                ovf_nxt, neg_nxt;

  assign py_m = side_m_r.py;
  assign ny_m = side_m_r.ny;

  always_comb begin
    ox_nxt   = sat_pos((PROD_W+1)'(m_px_c_r));
    oz_nxt   = sat_pos(-(PROD_W+1)'(m_px_s_r));
    abs_x    = m_nx_c_r[NPROD_W-1] ? -m_nx_c_r : m_nx_c_r;
    abs_z    = m_nx_s_r[NPROD_W-1] ? -m_nx_s_r : m_nx_s_r;
    abs_y    = ny_m[NRM_W-1] ? -(NRM_W+1)'(ny_m) : (NRM_W+1)'(ny_m);
    half_len = len_m_r >> 1;
    // Rounded dividends: |num| * 256 + len/2 for x and z, |ny| * 2^24 + len/2 for y
    dvd[0]   = NUM_W'({abs_x, 8'b0}) + NUM_W'(half_len);
    dvd[1]   = NUM_W'({abs_y, 24'b0}) + NUM_W'(half_len);
    dvd[2]   = NUM_W'({abs_z, 8'b0}) + NUM_W'(half_len);
    for (int l = 0; l < 3; l++) begin
      ovf_nxt[l] = dvd[l][NUM_W-1:NQ_W] >= len_m_r;
    end
    neg_nxt[0] = !m_nx_c_r[NPROD_W-1] && (m_nx_c_r != '0);
    neg_nxt[1] = !ny_m[NRM_W-1] && (ny_m != '0);
    neg_nxt[2] = m_nx_s_r[NPROD_W-1];
  end

  // Prep stage registers
  logic [LEN_W-1:0] nd_rem_r [0:2];
  logic [NQ_W-1:0]  nd_low_r [0:2];
  logic [LEN_W-1:0] len_p_r;
  post_t            post_r, post_t2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        nd_rem_r[l] <= ovf_nxt[l] ? '0 : dvd[l][NUM_W-1:NQ_W];
        nd_low_r[l] <= dvd[l][NQ_W-1:0];
      end
      len_p_r    <= len_m_r;
      post_r.ox  <= side_m_r.err ? '0 : ox_nxt;
      post_r.oy  <= side_m_r.err ? '0 : py_m;
      post_r.oz  <= side_m_r.err ? '0 : oz_nxt;
      post_r.ovf <= ovf_nxt;
      post_r.neg <= neg_nxt;
      post_r.err <= side_m_r.err;
      post_r.zn  <= side_m_r.zn;
    end
  end

  // Normal dividers, one per component
  logic [NQ_W-1:0] nq [0:2];

  for (genvar l = 0; l < 3; l++) begin : g_ndiv
    sorv_div #(.DW(LEN_W), .QW(NQ_W), .BPS(DIG_PER_STAGE)) u_ndiv (
      .clk     (clk),
      .en      (adv),
      .rem_in  (nd_rem_r[l]),
      .low_in  (nd_low_r[l]),
      .dvs_in  (len_p_r),
      .quo_out (nq[l])
    );
  end

  sorv_delay #(.W($bits(post_t)), .N(NDIV_LAT)) u_post_dly (
    .clk (clk),
    .en  (adv),
    .d   (post_r),
    .q   (post_t2)
  );

  // Apply sign and saturate to Q1.16 range
  function automatic logic signed [NRM_W-1:0] sat_nrm(input logic neg, input logic ovf,
                                                      input logic [NQ_W-1:0] q);
    logic signed [NRM_W-1:0] o;
    logic [NQ_W:0]           qe;
    qe = {1'b0, q};
    if (neg) begin
      if (ovf || (qe > (NQ_W+1)'(NRM_MIN_MAG))) begin
        o = {1'b1, {(NRM_W-1){1'b0}}};
      end else begin
        o = NRM_W'(-qe);
      end
    end else begin
      if (ovf || (qe > (NQ_W+1)'(NRM_MAX))) begin
        o = {1'b0, {(NRM_W-1){1'b1}}};
      end else begin
        o = NRM_W'(qe);
      end
    end
    return o;
  endfunction

  // Output register
  logic signed [POS_W-1:0] out_x_r, out_y_r, out_z_r;
  logic signed [NRM_W-1:0] nrm_x_r, nrm_y_r, nrm_z_r;
  logic                    zn_r, err_r;
  logic                    nrm_kill;

  assign nrm_kill = post_t2.zn || post_t2.err;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= post_t2.ox;
      out_y_r <= post_t2.oy;
      out_z_r <= post_t2.oz;
      nrm_x_r <= nrm_kill ? '0 : sat_nrm(post_t2.neg[0], post_t2.ovf[0], nq[0]);
      nrm_y_r <= nrm_kill ? '0 : sat_nrm(post_t2.neg[1], post_t2.ovf[1], nq[1]);
      nrm_z_r <= nrm_kill ? '0 : sat_nrm(post_t2.neg[2], post_t2.ovf[2], nq[2]);
      zn_r    <= post_t2.zn;
      err_r   <= post_t2.err;
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_z           = out_z_r;
  assign out_nrm_out_x   = nrm_x_r;
  assign out_nrm_out_y   = nrm_y_r;
  assign out_nrm_out_z   = nrm_z_r;
  assign out_zero_normal = zn_r;
  assign out_index_error = err_r;

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_x == '0 && out_y == '0 && out_z == '0 &&
      out_nrm_out_x == '0 && out_nrm_out_y == '0 && out_nrm_out_z == '0)
    else $error("index error result carries nonzero vector");

  a_zn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_normal |->
      out_nrm_out_x == '0 && out_nrm_out_y == '0 && out_nrm_out_z == '0)
    else $error("zero normal result carries nonzero normal");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transfer lost at pipeline entry");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(step_count_r) <= MAX_STEPS) || (step_count_r == CNT_W'(RESET_STEPS)))
    else $error("step count above cap");

endmodule
